// File: src/lsfr_pkg.sv
`default_nettype none
package lsfr_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] DIST_CMD   = 8'hb0;

  localparam logic [15:0] POLY_RESET   = 16'h8005;
  localparam logic [7:0]  ADDR_RESET   = 8'h80;
  localparam logic        SCALES_RESET = 1'b1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_POLY   = 2'd0;
  localparam logic [1:0] REG_ADDR   = 2'd1;
  localparam logic [1:0] REG_SCALES = 2'd2;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] SCALE_UNIT = 2'd0;
  localparam logic [1:0] SCALE_TENTH = 2'd1;
  localparam logic [1:0] SCALE_TEN  = 2'd2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] poly;
    logic [7:0]  addr;
    logic        scales;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [13:0] meas_index;
    logic [12:0] range_raw;
    logic        glare;
    logic        warn;
    logic        stop;
    logic [1:0]  scale;
    logic        crc_good;
    logic [16:0] frame_length;
    logic        is_dist;
  } res_t;

endpackage
`default_nettype wire

// File: src/lsfr_parse.sv
`default_nettype none
module lsfr_parse (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 byte_valid,
  input  wire [7:0]           byte_data,
  input  lsfr_pkg::cfg_t      cfg,
  output logic                push,
  output lsfr_pkg::res_t      push_res
);
  import lsfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_ADDR, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [13:0] mcount_r, mcount_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [1:0]  scale_r, scale_nxt;
  logic [13:0] midx_r, midx_nxt;
  logic [15:0] crc_fed;
  logic [15:0] len_full;

  assign crc_fed = {crc_r[14:0], 1'b0} ^ (crc_r[15] ? cfg.poly : 16'h0000)
                 ^ {prev_r, byte_data};
  assign len_full = {byte_data, len_r[7:0]};

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    prev_nxt   = prev_r;
    crc_lo_nxt = crc_lo_r;
    cmd_nxt    = cmd_r;
    mcount_nxt = mcount_r;
    held_nxt   = held_r;
    scale_nxt  = scale_r;
    midx_nxt   = midx_r;
    push       = 1'b0;
    push_res   = '0;
    if (byte_valid) begin
      case (phase_r)
        PH_HUNT, PH_ADDR: begin
          if (phase_r == PH_ADDR && byte_data == cfg.addr) begin
            crc_nxt   = crc_fed;
            prev_nxt  = byte_data;
            phase_nxt = PH_LEN_LO;
          end else if (byte_data == START_BYTE) begin
            crc_nxt    = {8'h00, START_BYTE};
            prev_nxt   = START_BYTE;
            len_nxt    = '0;
            cnt_nxt    = '0;
            crc_lo_nxt = '0;
            cmd_nxt    = '0;
            mcount_nxt = '0;
            held_nxt   = '0;
            scale_nxt  = SCALE_UNIT;
            midx_nxt   = '0;
            phase_nxt  = PH_ADDR;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LEN_LO: begin
          crc_nxt   = crc_fed;
          prev_nxt  = byte_data;
          len_nxt   = {8'h00, byte_data};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_nxt   = crc_fed;
          prev_nxt  = byte_data;
          len_nxt   = len_full;
          cnt_nxt   = '0;
          phase_nxt = (len_full == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_nxt  = crc_fed;
          prev_nxt = byte_data;
          if (cnt_r == 17'd0) begin
            cmd_nxt = byte_data;
          end else if (cnt_r == 17'd1) begin
            held_nxt = byte_data;
          end else if (cnt_r == 17'd2) begin
            mcount_nxt = {byte_data[5:0], held_r};
            if (!cfg.scales) begin
              scale_nxt = SCALE_UNIT;
            end else if (byte_data[7]) begin
              scale_nxt = SCALE_TEN;
            end else if (byte_data[6]) begin
              scale_nxt = SCALE_TENTH;
            end else begin
              scale_nxt = SCALE_UNIT;
            end
            midx_nxt = '0;
          end else if (cnt_r[0]) begin
            held_nxt = byte_data;
          end else if (cmd_r == DIST_CMD && midx_r < mcount_r) begin
            push                = 1'b1;
            push_res.kind       = KIND_MEAS;
            push_res.meas_index = midx_r;
            push_res.range_raw  = {byte_data[4:0], held_r};
            push_res.glare      = byte_data[5];
            push_res.warn       = byte_data[6];
            push_res.stop       = byte_data[7];
            push_res.scale      = scale_r;
            midx_nxt            = midx_r + 14'd1;
          end
          cnt_nxt = cnt_r + 17'd1;
          if (cnt_nxt >= {1'b0, len_r}) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = byte_data;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          push                  = 1'b1;
          push_res.kind         = KIND_END;
          push_res.crc_good     = ({byte_data, crc_lo_r} == crc_r);
          push_res.frame_length = {1'b0, len_r} + 17'd6;
          push_res.is_dist      = (len_r != 16'h0000) && (cmd_r == DIST_CMD);
          phase_nxt             = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= '0;
      prev_r   <= '0;
      crc_lo_r <= '0;
      cmd_r    <= '0;
      mcount_r <= '0;
      held_r   <= '0;
      scale_r  <= SCALE_UNIT;
      midx_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      prev_r   <= prev_nxt;
      crc_lo_r <= crc_lo_nxt;
      cmd_r    <= cmd_nxt;
      mcount_r <= mcount_nxt;
      held_r   <= held_nxt;
      scale_r  <= scale_nxt;
      midx_r   <= midx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/lsfr_queue.sv
`default_nettype none
module lsfr_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  lsfr_pkg::res_t      push_res,
  output logic                space,
  input  wire                 pop,
  output logic                avail,
  output lsfr_pkg::res_t      head
);
  import lsfr_pkg::*;

  res_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign space   = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign avail   = (cnt_r != '0);
  assign head    = mem[rptr_r];
  assign do_push = push && space;
  assign do_pop  = pop && avail;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/lsfr_out.sv
`default_nettype none
module lsfr_out (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             avail,
  input  lsfr_pkg::res_t                  head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [lsfr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import lsfr_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  user_r, user_nxt;

  assign pop = avail && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    if (pop) begin
      valid_nxt = 1'b1;
      user_nxt  = head.kind;
      data_nxt  = {5'b00000, head.is_dist, head.frame_length, head.crc_good,
                   head.scale, head.stop, head.warn, head.glare,
                   head.range_raw, head.meas_index};
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

// File: src/laser_scanner_frame_receiver_unit.sv
// Serial telegram receiver with CRC16 check.
// in_*: one received byte per beat (in_tdata[7:0]).
// out_*: one result per beat; out_tuser is the kind (0 measurement, 1 frame end).
//   Measurements carry index, raw range, flags and scale code; a frame end
//   carries the CRC verdict, total frame length and the distance-frame flag.
// cfg_*: register port for polynomial (0x0), address byte (0x4), scale switch (0x8).
// Throughput is one byte per cycle while the queue has space: the CRC is a single-step shift-and-XOR.
// A result reaches out_tvalid via the queue: the parser writes a four-entry
// queue on the edge that accepts the byte causing it, and the output register
// then loads from the queue head once it is empty or out_tready is high.
// When the receiver stalls, results collect in the queue; in_tready falls
// only once the queue is full, and nothing is dropped.
// Synchronous reset returns the parser to start-byte hunting, empties the
// queue and output register, and restores the register reset values.
`default_nettype none
module laser_scanner_frame_receiver_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [lsfr_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] in_byte
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [13:0] meas_index, [26:14] range_raw, [27] glare_flag, [28] warn_field_flag,
  // [29] stop_field_flag, [31:30] scale_code, [32] crc_good,
  // [49:33] frame_length, [50] is_distance_frame, [55:51] zero
  output logic [lsfr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // [0] result_kind
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire [lsfr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire [lsfr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lsfr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import lsfr_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       in_acc;
  logic       push;
  res_t       push_res;
  logic       space;
  logic       pop;
  logic       avail;
  res_t       head;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_POLY:   cfg_nxt.poly   = cfg_pwdata[15:0];
        REG_ADDR:   cfg_nxt.addr   = cfg_pwdata[7:0];
        REG_SCALES: cfg_nxt.scales = cfg_pwdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLY:   cfg_prdata = {16'h0000, cfg_r.poly};
      REG_ADDR:   cfg_prdata = {24'h000000, cfg_r.addr};
      REG_SCALES: cfg_prdata = {31'd0, cfg_r.scales};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly   <= POLY_RESET;
      cfg_r.addr   <= ADDR_RESET;
      cfg_r.scales <= SCALES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = space;
  assign in_acc    = in_tvalid && in_tready;

  lsfr_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_acc),
    .byte_data  (in_tdata),
    .cfg        (cfg_r),
    .push       (push),
    .push_res   (push_res)
  );

  lsfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .space    (space),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  lsfr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .avail      (avail),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: src/lsfr_checker.sv
`default_nettype none
module lsfr_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [lsfr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                             out_tuser
);
  import lsfr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tdata[31:0] == 32'h0 && out_tdata[55:51] == 5'h0)
    else $error("frame end beat carries measurement fields");

  a_meas_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_MEAS |-> out_tdata[55:32] == 24'h0
      && out_tdata[31:30] != 2'd3)
    else $error("measurement beat carries frame end fields or bad scale");

  a_end_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tdata[49:33] >= 17'd6)
    else $error("frame length shorter than header and CRC");

endmodule

bind laser_scanner_frame_receiver_unit lsfr_checker u_lsfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
